// ===== design/lbce_pkg.sv =====
// ----------------------------------------------------------------------------
// lbce_pkg
// Shared types and constants of the LED booster command encoder: opcodes,
// command bytes, beat payloads and the burst handed to the serializer.
// ----------------------------------------------------------------------------
package lbce_pkg;

  // most bytes one command can produce
  localparam int unsigned NumBytes = 6;
  localparam int unsigned CntW     = $clog2(NumBytes + 1);
  localparam int unsigned IdxW     = $clog2(NumBytes);

  // command bytes of the coprocessor protocol
  localparam logic [7:0] ByteInit = 8'hB1;
  localparam logic [7:0] ByteBits = 8'd24;
  localparam logic [7:0] ByteShow = 8'hB2;
  localparam logic [7:0] ByteRgb  = 8'hA1;
  localparam logic [7:0] ByteOne  = 8'hA4;
  localparam logic [7:0] ByteAll  = 8'hA5;
  localparam logic [7:0] ColorRst = 8'd255;

  // a frame may not reach this many bytes
  localparam logic [8:0] FrameLimit = 9'd255;

  // configuration register indexes
  localparam logic CfgLedCount   = 1'b0;
  localparam logic CfgColorOrder = 1'b1;

  typedef enum logic [1:0] {
    OpInit   = 2'd0,
    OpSetOne = 2'd1,
    OpSetAll = 2'd2,
    OpShow   = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] led_index;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_of_item;
    logic       release_select;
    logic       fault;
  } out_t;

  // all beats of one command, ready for serialization
  typedef struct packed {
    logic [NumBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
    logic                     finish;
    logic                     fault;
  } burst_t;

endpackage

// ===== design/led_booster_command_encoder.sv =====
// ----------------------------------------------------------------------------
// led_booster_command_encoder
// Turns LED commands into the SPI byte stream of an LED driver coprocessor.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the in_* valid/ready channel, one command per beat.
//   Bytes leave on the out_* valid/ready channel, one byte per beat, with
//   last_of_item on the final byte of a command and release_select where
//   the chip select drops. A frame that would reach 255 bytes yields one
//   beat with fault set instead; the fault then sticks until reset.
//   Configuration (LED count, color order) is written through cfg_we_i;
//   the user must write it only while idle; the block does not enforce it.
// Flow:
//   An accepted command waits in the input register and moves into the
//   serializer once that is free; its first byte is then on the output.
//   A command produces 1 to 6 bytes, handed out one beat per cycle by the
//   serializer while the receiver takes them; the next command waits
//   in the input register and follows with no gap.
// Reset and stalls:
//   Reset empties both stages, restores the cached color to white, clears
//   the frame count, select and fault. A stalled receiver holds the current
//   byte; one more command is still taken into the input register.
// ----------------------------------------------------------------------------
module led_booster_command_encoder import lbce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_wdata_i
);

  logic       inq_valid_q;
  in_t        inq_data_q;
  logic [7:0] led_count_q;
  logic       color_order_q;
  logic       ser_free;
  logic       load;
  burst_t     burst;

  assign load       = inq_valid_q && ser_free;
  assign in_ready_o = !inq_valid_q || load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q   <= 8'd64;
      color_order_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgLedCount:   led_count_q   <= cfg_wdata_i;
        CfgColorOrder: color_order_q <= cfg_wdata_i[0];
        default:       ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      inq_valid_q <= 1'b1;
    end else if (load) begin
      inq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_data_q <= in_data_i;
    end
  end

  lbce_encoder u_encoder (
    .clk_i,
    .rst_ni,
    .load_i        (load),
    .item_i        (inq_data_q),
    .led_count_i   (led_count_q),
    .color_order_i (color_order_q),
    .burst_o       (burst)
  );

  lbce_serializer u_serializer (
    .clk_i,
    .rst_ni,
    .load_i      (load),
    .burst_i     (burst),
    .free_o      (ser_free),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

// ===== design/lbce_encoder.sv =====
// ----------------------------------------------------------------------------
// lbce_encoder
// Builds the byte burst of one command and keeps the frame state: cached
// color, frame byte count, select and the sticky frame limit fault.
// ----------------------------------------------------------------------------
module lbce_encoder import lbce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  in_t        item_i,
  input  logic [7:0] led_count_i,
  input  logic       color_order_i,
  output burst_t     burst_o
);

  logic [7:0] cache_r_q, cache_g_q, cache_b_q;
  logic [7:0] frame_bytes_q, frame_bytes_d;
  logic       select_q, select_d;
  logic       fault_q, fault_d;

  burst_t     cmd;
  logic       new_colour;
  logic       over_limit;
  logic [7:0] c_first, c_last;
  logic [8:0] frame_sum;
  opcode_e    op;

  assign op         = opcode_e'(item_i.opcode);
  assign new_colour = (item_i.red != cache_r_q) || (item_i.green != cache_g_q) ||
                      (item_i.blue != cache_b_q);
  assign c_first    = color_order_i ? item_i.blue : item_i.red;
  assign c_last     = color_order_i ? item_i.red  : item_i.blue;

  // byte list of the command
  always_comb begin
    cmd = '0;
    case (op)
      OpInit: begin
        cmd.bytes[0] = ByteInit;
        cmd.bytes[1] = led_count_i;
        cmd.bytes[2] = ByteBits;
        cmd.count    = CntW'(3);
        cmd.finish   = 1'b1;
      end
      OpShow: begin
        cmd.bytes[0] = ByteRgb;
        cmd.bytes[4] = ByteShow;
        cmd.count    = CntW'(5);
        cmd.finish   = 1'b1;
      end
      OpSetOne: begin
        if (new_colour) begin
          cmd.bytes[0] = ByteRgb;
          cmd.bytes[1] = c_first;
          cmd.bytes[2] = item_i.green;
          cmd.bytes[3] = c_last;
          cmd.bytes[4] = ByteOne;
          cmd.bytes[5] = item_i.led_index;
          cmd.count    = CntW'(6);
        end else begin
          cmd.bytes[0] = ByteOne;
          cmd.bytes[1] = item_i.led_index;
          cmd.count    = CntW'(2);
        end
      end
      OpSetAll: begin
        if (new_colour) begin
          cmd.bytes[0] = ByteRgb;
          cmd.bytes[1] = c_first;
          cmd.bytes[2] = item_i.green;
          cmd.bytes[3] = c_last;
          cmd.bytes[4] = ByteAll;
          cmd.count    = CntW'(5);
        end else begin
          cmd.bytes[0] = ByteAll;
          cmd.count    = CntW'(1);
        end
      end
      default: cmd = '0;
    endcase
  end

  // frame limit check
  assign frame_sum  = {1'b0, frame_bytes_q} + 9'(cmd.count);
  assign over_limit = frame_sum >= FrameLimit;

  // fault turns the burst into one empty faulting beat
  always_comb begin
    if (fault_q || over_limit) begin
      burst_o       = '0;
      burst_o.count = CntW'(1);
      burst_o.fault = 1'b1;
    end else begin
      burst_o = cmd;
    end
  end

  // next frame state
  always_comb begin
    frame_bytes_d = frame_bytes_q;
    select_d      = select_q;
    fault_d       = fault_q;
    if (load_i && !fault_q) begin
      if (over_limit) begin
        fault_d = 1'b1;
      end else if (cmd.finish) begin
        frame_bytes_d = '0;
        select_d      = 1'b0;
      end else begin
        frame_bytes_d = frame_sum[7:0];
        select_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_r_q     <= ColorRst;
      cache_g_q     <= ColorRst;
      cache_b_q     <= ColorRst;
      frame_bytes_q <= '0;
      select_q      <= 1'b0;
      fault_q       <= 1'b0;
    end else begin
      frame_bytes_q <= frame_bytes_d;
      select_q      <= select_d;
      fault_q       <= fault_d;
      if (load_i && !fault_q && !over_limit) begin
        if (cmd.finish) begin
          cache_r_q <= ColorRst;
          cache_g_q <= ColorRst;
          cache_b_q <= ColorRst;
        end else if (new_colour) begin
          cache_r_q <= item_i.red;
          cache_g_q <= item_i.green;
          cache_b_q <= item_i.blue;
        end
      end
    end
  end

endmodule

// ===== design/lbce_serializer.sv =====
// ----------------------------------------------------------------------------
// lbce_serializer
// Holds one command burst and hands it out one beat per cycle while the
// output channel is ready; frees itself as the last beat is taken.
// ----------------------------------------------------------------------------
module lbce_serializer import lbce_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  burst_t burst_i,
  output logic   free_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output out_t   out_data_o
);

  burst_t          burst_q;
  logic            valid_q;
  logic [IdxW-1:0] idx_q;
  logic            fire;
  logic            last;

  assign fire   = valid_q && out_ready_i;
  assign last   = (CntW'(idx_q) + CntW'(1)) == burst_q.count;
  assign free_o = !valid_q || (fire && last);

  // current beat
  assign out_valid_o               = valid_q;
  assign out_data_o.tx_byte        = burst_q.bytes[idx_q];
  assign out_data_o.last_of_item   = last;
  assign out_data_o.release_select = last && burst_q.finish;
  assign out_data_o.fault          = burst_q.fault;

  // burst payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  // beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (fire && last) begin
      valid_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

endmodule

// ===== bench/command_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_stream_checker
// Watches both channels and the register port of the LED command encoder.
// Every command beat is turned into the SPI bytes it should produce. Every
// output beat is compared, field by field, with the oldest of those bytes.
// ----------------------------------------------------------------------------
module command_stream_checker import lbce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);

  // shadow registers and encoder state
  logic [7:0] led_count_q;
  logic       color_order_q;
  logic [7:0] cache_red_q, cache_green_q, cache_blue_q;
  logic [7:0] frame_bytes_q;
  logic       select_q;
  logic       fault_q;

  out_t        spi_bytes_due[$];
  int unsigned mismatch_count = 0;

  assign errors_o = mismatch_count;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic out_t fault_beat();
    out_t beat;
    beat = '0;
    beat.last_of_item = 1'b1;
    beat.fault        = 1'b1;
    return beat;
  endfunction

  // work out the bytes of one command and update the encoder state
  task automatic encode_command(input in_t cmd);
    logic [7:0] seq [6];
    int         n;
    int         k;
    logic       closes;
    logic       fresh;
    out_t       beat;
    n      = 0;
    closes = 1'b0;
    fresh  = 1'b0;
    if (fault_q) begin
      spi_bytes_due.push_back(fault_beat());
      return;
    end
    case (opcode_e'(cmd.opcode))
      OpInit: begin
        seq[0] = ByteInit;
        seq[1] = led_count_q;
        seq[2] = ByteBits;
        n      = 3;
        closes = 1'b1;
      end
      OpShow: begin
        seq[0] = ByteRgb;
        seq[1] = 8'd0;
        seq[2] = 8'd0;
        seq[3] = 8'd0;
        seq[4] = ByteShow;
        n      = 5;
        closes = 1'b1;
      end
      default: begin
        fresh = {cmd.red, cmd.green, cmd.blue} !=
                {cache_red_q, cache_green_q, cache_blue_q};
        // color bytes only when the color changed
        if (fresh) begin
          seq[0] = ByteRgb;
          seq[1] = color_order_q ? cmd.blue : cmd.red;
          seq[2] = cmd.green;
          seq[3] = color_order_q ? cmd.red : cmd.blue;
          n      = 4;
        end
        if (opcode_e'(cmd.opcode) == OpSetOne) begin
          seq[n]   = ByteOne;
          seq[n+1] = cmd.led_index;
          n        = n + 2;
        end else begin
          seq[n] = ByteAll;
          n      = n + 1;
        end
      end
    endcase

    // frame byte limit: one fault beat and the fault sticks
    if ({1'b0, frame_bytes_q} + 9'(n) >= FrameLimit) begin
      fault_q = 1'b1;
      spi_bytes_due.push_back(fault_beat());
      return;
    end

    for (k = 0; k < n; k++) begin
      beat.tx_byte        = seq[k];
      beat.last_of_item   = (k == n - 1);
      beat.release_select = closes && (k == n - 1);
      beat.fault          = 1'b0;
      spi_bytes_due.push_back(beat);
    end

    if (fresh) begin
      cache_red_q   = cmd.red;
      cache_green_q = cmd.green;
      cache_blue_q  = cmd.blue;
    end
    if (closes) begin
      select_q      = 1'b0;
      cache_red_q   = ColorRst;
      cache_green_q = ColorRst;
      cache_blue_q  = ColorRst;
      frame_bytes_q = 8'd0;
    end else begin
      select_q      = 1'b1;
      frame_bytes_q = frame_bytes_q + 8'(n);
    end
  endtask

  // compare one output beat with the oldest expected byte
  task automatic check_beat(input out_t got);
    out_t want;
    if (spi_bytes_due.size() == 0) begin
      report_mismatch("beat with nothing expected, tx_byte", got.tx_byte, 0);
      return;
    end
    want = spi_bytes_due.pop_front();
    if (got.tx_byte !== want.tx_byte)
      report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
    if (got.last_of_item !== want.last_of_item)
      report_mismatch("last_of_item", got.last_of_item, want.last_of_item);
    if (got.release_select !== want.release_select)
      report_mismatch("release_select", got.release_select, want.release_select);
    if (got.fault !== want.fault)
      report_mismatch("fault", got.fault, want.fault);
  endtask

  // output beat first, so a byte never meets the command taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q   = 8'd64;
      color_order_q = 1'b0;
      cache_red_q   = ColorRst;
      cache_green_q = ColorRst;
      cache_blue_q  = ColorRst;
      frame_bytes_q = 8'd0;
      select_q      = 1'b0;
      fault_q       = 1'b0;
      spi_bytes_due.delete();
      pending_o     = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_beat(out_data_i);
      if (in_valid_i && in_ready_i) encode_command(in_data_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgLedCount:   led_count_q   = cfg_wdata_i;
          CfgColorOrder: color_order_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      pending_o = spi_bytes_due.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives LED commands into the command encoder and takes its SPI bytes with
// random stalls on both sides. A directed run covers cached colors, both
// color orders, init in the middle of a frame and the LED count extremes;
// random frames follow under changing settings, and the run ends by filling
// a frame up to the byte limit to check the sticky fault.
// ----------------------------------------------------------------------------
module testbench import lbce_pkg::*; ();

  localparam int unsigned PhaseItems = 47;
  localparam int unsigned IdleLimit  = 2000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CfgLedCount;
  logic [7:0]  cfg_wdata = 8'd0;
  int unsigned bytes_pending;
  int unsigned errors;
  bit          no_idle   = 1'b0;
  // bytes of the open frame, kept across random phases
  int          open_bytes = 0;

  always #4 clk = ~clk;

  led_booster_command_encoder i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  command_stream_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (bytes_pending),
    .errors_o    (errors)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_t make_command(input opcode_e op, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] b,
                                       input logic [7:0] idx);
    in_t cmd;
    cmd.opcode    = op;
    cmd.red       = r;
    cmd.green     = g;
    cmd.blue      = b;
    cmd.led_index = idx;
    return cmd;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_command(input in_t cmd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold the sender until every expected byte has come out
  task automatic drain_bytes();
    in_valid <= 1'b0;
    @(negedge clk);
    while (bytes_pending != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic index, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // random frames: sets with repeated and fresh colors, inits, shows, noise
  task automatic run_random_frames(input int unsigned items);
    int unsigned sent;
    int          roll;
    in_t         cmd;
    logic [7:0]  r, g, b;
    sent       = 0;
    r          = 8'($urandom);
    g          = 8'($urandom);
    b          = 8'($urandom);
    while (sent < items) begin
      roll = $urandom_range(0, 99);
      cmd  = make_command(OpSetAll, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
      if (roll < 10) begin
        cmd.opcode = 2'($urandom);
      end else if (roll < 20) begin
        cmd.opcode = OpInit;
      end else if (roll < 35) begin
        cmd.opcode = OpShow;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          {r, g, b} = {3{8'hFF}};
        end else if (roll < 20) begin
          r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else if (roll >= 60) begin
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
        end
        cmd.red    = r;
        cmd.green  = g;
        cmd.blue   = b;
        cmd.opcode = $urandom_range(0, 1) ? OpSetOne : OpSetAll;
      end
      // keep well clear of the frame limit here
      if (open_bytes > 200) cmd.opcode = OpShow;
      if (cmd.opcode == OpInit || cmd.opcode == OpShow) open_bytes = 0;
      else open_bytes = open_bytes + 7;
      push_command(cmd);
      sent++;
    end
  endtask

  // one open frame grown up to the byte limit, then the sticky fault
  task automatic run_frame_limit();
    int         k;
    logic [7:0] g, b;
    g = 8'($urandom);
    b = 8'($urandom);
    push_command(make_command(OpShow, 8'd0, 8'd0, 8'd0, 8'd0));
    // 50 fresh colors of five bytes each fill 250 bytes
    for (k = 0; k < 50; k++)
      push_command(make_command(OpSetAll, 8'(k), g, b, 8'($urandom)));
    // cached color: 252, 253, 254 still fit, the next one hits the limit
    push_command(make_command(OpSetOne, 8'd49, g, b, 8'($urandom)));
    push_command(make_command(OpSetAll, 8'd49, g, b, 8'($urandom)));
    push_command(make_command(OpSetAll, 8'd49, g, b, 8'($urandom)));
    push_command(make_command(OpSetAll, 8'd49, g, b, 8'($urandom)));
    for (k = 0; k < 8; k++)
      push_command(make_command(opcode_e'(k % 4), 8'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom)));
  endtask

  // receiver stalls
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // watchdog on cycles without any beat
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int p;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default settings: count 64, red green blue
    push_command(make_command(OpInit, 8'h12, 8'h34, 8'h56, 8'h78));
    push_command(make_command(OpSetOne, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    push_command(make_command(OpSetOne, 8'h00, 8'h00, 8'h00, 8'hFF));
    push_command(make_command(OpSetOne, 8'h00, 8'h00, 8'h00, 8'h5A));
    push_command(make_command(OpSetAll, 8'hAA, 8'h55, 8'h0F, 8'hC3));
    push_command(make_command(OpSetAll, 8'hAA, 8'h55, 8'h0F, 8'h3C));
    // init in the middle of a frame
    push_command(make_command(OpInit, 8'hFF, 8'h00, 8'hFF, 8'h00));
    push_command(make_command(OpSetAll, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_command(make_command(OpShow, 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom)));
    drain_bytes();
    write_register(CfgLedCount, 8'd0);
    write_register(CfgColorOrder, 8'd1);
    push_command(make_command(OpInit, 8'h00, 8'h00, 8'h00, 8'h00));
    push_command(make_command(OpSetOne, 8'h01, 8'h02, 8'h03, 8'h80));
    push_command(make_command(OpSetAll, 8'hFF, 8'h00, 8'h80, 8'h01));
    push_command(make_command(OpSetAll, 8'h00, 8'hFF, 8'h7F, 8'hFE));
    push_command(make_command(OpShow, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    drain_bytes();
    write_register(CfgLedCount, 8'd255);
    push_command(make_command(OpInit, 8'h55, 8'hAA, 8'h55, 8'hAA));
    push_command(make_command(OpShow, 8'hAA, 8'h55, 8'hAA, 8'h55));

    // random frames under changing settings, one phase with no stalls
    for (p = 0; p < 5; p++) begin
      drain_bytes();
      write_register(CfgLedCount, (p == 1) ? 8'd255 : (p == 3) ? 8'd0 : 8'($urandom));
      write_register(CfgColorOrder, {7'($urandom), p[0]});
      no_idle = (p == 2);
      run_random_frames(PhaseItems);
    end
    no_idle = 1'b0;

    drain_bytes();
    run_frame_limit();

    in_valid <= 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
